>>> rtl/core/world_to_screen_projection_macros.svh
// Assertion helpers for the projection core.
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

`ifndef ASSERT_OFF
`define WSP_ASSERT_IMP(lbl, clk, rstn, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (con)) \
        else $error("assertion failed");
`define WSP_ASSERT_NEXT(lbl, clk, rstn, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (con)) \
        else $error("assertion failed");
`else
`define WSP_ASSERT_IMP(lbl, clk, rstn, pre, con)
`define WSP_ASSERT_NEXT(lbl, clk, rstn, pre, con)
`endif

`endif

>>> rtl/core/wsp_pkg.sv
package wsp_pkg;

    localparam int SCREEN_BITS = 12;
    localparam int OUT_BITS    = SCREEN_BITS + 4;
    localparam int SCALE_BITS  = SCREEN_BITS + 3;
    localparam int PROD_W      = 48;
    localparam int CLIP_W      = 52;
    localparam int P_W         = CLIP_W + SCALE_BITS;
    localparam int CFG_IDX_W   = 3;

    // 1e-4 in Q.28
    localparam logic signed [CLIP_W-1:0] EPS_CLIP = CLIP_W'(26843);

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic                visible;
        logic [OUT_BITS-1:0] screen_x;
        logic [OUT_BITS-1:0] screen_y;
    } out_item_t;

    // classified point handed from front to back
    typedef struct packed {
        logic              visible;
        logic [CLIP_W-1:0] w;
        logic [CLIP_W-1:0] ax;
        logic [CLIP_W-1:0] ay;
    } clip_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/wsp_front.sv
module wsp_front
    import wsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [3:0][63:0] matrix,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    input  q_status_t        q_status,
    output logic             push,
    output clip_item_t       push_item
);

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic adv_a, adv_b, adv_c, adv_d;

    in_item_t                  pt_reg;
    logic signed [PROD_W-1:0]  prod_reg  [4][3];
    logic signed [PROD_W-1:0]  prod_next [4][3];
    logic signed [31:0]        cterm_reg [4];
    logic signed [CLIP_W-1:0]  clip_reg  [4];
    logic signed [CLIP_W-1:0]  clip_next [4];
    clip_item_t                item_reg, item_next;
    logic signed [31:0]        pos_s [3];

    assign adv_d    = !vd_reg || !q_status.full;
    assign adv_c    = !vc_reg || adv_d;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign in_stall = !adv_a;
    assign push      = vd_reg && !q_status.full;
    assign push_item = item_reg;

    assign pos_s[0] = pt_reg.pos_x;
    assign pos_s[1] = pt_reg.pos_y;
    assign pos_s[2] = pt_reg.pos_z;

    always_comb
    begin
        logic signed [15:0] coef;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef = matrix[r][16*c +: 16];
                prod_next[r][c] = PROD_W'(coef) * PROD_W'(pos_s[c]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            clip_next[r] = CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                         + CLIP_W'(prod_reg[r][2]) + CLIP_W'(cterm_reg[r]);
        end
    end

    always_comb
    begin
        logic signed [CLIP_W-1:0] cx, cy, cz, cw;
        cx = clip_reg[0];
        cy = clip_reg[1];
        cz = clip_reg[2];
        cw = clip_reg[3];
        item_next.visible = (cw > EPS_CLIP)
                         && (cx >= -cw) && (cx <= cw)
                         && (cy >= -cw) && (cy <= cw)
                         && (cz >= -cw) && (cz <= cw);
        item_next.w  = cw;
        item_next.ax = cx + cw;
        item_next.ay = cw - cy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= in_valid;
            if (adv_b)
                vb_reg <= va_reg;
            if (adv_c)
                vc_reg <= vb_reg;
            if (adv_d)
                vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
            pt_reg <= in_item;
        if (adv_b)
        begin
            prod_reg <= prod_next;
            for (int r = 0; r < 4; r++)
                cterm_reg[r] <= {matrix[r][63:48], 16'h0000};
        end
        if (adv_c)
            clip_reg <= clip_next;
        if (adv_d)
            item_reg <= item_next;
    end

endmodule

>>> rtl/core/wsp_queue.sv
`include "world_to_screen_projection_macros.svh"

module wsp_queue
    import wsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  clip_item_t push_item,
    input  logic       pop,
    output clip_item_t pop_item,
    output q_status_t  status
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = AW + 1;

    clip_item_t       mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_item     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers wrap at DEPTH, which need not be a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    `WSP_ASSERT_IMP(a_push_room, clk, rst_n, push, count_reg < CNT_W'(DEPTH))
    `WSP_ASSERT_IMP(a_pop_data, clk, rst_n, pop, count_reg != '0)
    `WSP_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/core/wsp_back.sv
module wsp_back
    import wsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SCREEN_BITS-1:0] screen_width,
    input  logic [SCREEN_BITS-1:0] screen_height,
    input  q_status_t              q_status,
    input  clip_item_t             pop_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    localparam int QB = OUT_BITS;

    // stage 0 scales, stages 1..QB each resolve one quotient bit
    logic [QB:0]         v_reg;
    logic [QB:0]         adv;
    logic                vis_reg [QB+1];
    logic [CLIP_W-1:0]   w_reg   [QB+1];
    logic [P_W-1:0]      rx_reg  [QB+1];
    logic [P_W-1:0]      ry_reg  [QB+1];
    logic [OUT_BITS-1:0] qx_reg  [QB+1];
    logic [OUT_BITS-1:0] qy_reg  [QB+1];

    logic [SCALE_BITS-1:0] sx, sy;

    assign sx = {screen_width, 3'b000};
    assign sy = {screen_height, 3'b000};

    assign adv[QB] = !v_reg[QB] || !out_stall;
    assign pop     = !q_status.empty && adv[0];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_adv
            assign adv[k] = !v_reg[k] || adv[k+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv[0])
            v_reg[0] <= !q_status.empty;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            vis_reg[0] <= pop_item.visible;
            w_reg[0]   <= pop_item.w;
            rx_reg[0]  <= P_W'(pop_item.ax) * P_W'(sx);
            ry_reg[0]  <= P_W'(pop_item.ay) * P_W'(sy);
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
        end
    end

    generate
        for (k = 0; k < QB; k++)
        begin : g_div
            localparam int BIT = QB - 1 - k;
            logic [P_W-1:0] dvs;
            logic           bx, by;

            assign dvs = P_W'(w_reg[k]) << BIT;
            assign bx  = vis_reg[k] && (rx_reg[k] >= dvs);
            assign by  = vis_reg[k] && (ry_reg[k] >= dvs);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k+1] <= 1'b0;
                else if (adv[k+1])
                    v_reg[k+1] <= v_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv[k+1])
                begin
                    vis_reg[k+1] <= vis_reg[k];
                    w_reg[k+1]   <= w_reg[k];
                    rx_reg[k+1]  <= bx ? rx_reg[k] - dvs : rx_reg[k];
                    ry_reg[k+1]  <= by ? ry_reg[k] - dvs : ry_reg[k];
                    qx_reg[k+1]  <= qx_reg[k] | (OUT_BITS'(bx) << BIT);
                    qy_reg[k+1]  <= qy_reg[k] | (OUT_BITS'(by) << BIT);
                end
            end
        end
    endgenerate

    assign out_valid         = v_reg[QB];
    assign out_item.visible  = vis_reg[QB];
    assign out_item.screen_x = qx_reg[QB];
    assign out_item.screen_y = qy_reg[QB];

endmodule

>>> rtl/core/world_to_screen_projection.sv
// Projects world points (Q16.16) through a software-loaded 4x4 Q4.12 matrix
// and maps visible points to the viewport in unsigned Q12.4. One point is
// taken per cycle while in_stall is low; a result passes the four-stage
// matrix front, the queue slot, the scaling multiply and the 16 one-bit
// stages of the restoring divider that forms (x+w)*width*8/w and
// (w-y)*height*8/w. Invisible points return zero coordinates. The user must
// write registers only while no point is in flight; no logic enforces it.
module world_to_screen_projection
    import wsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item
);

    logic [3:0][63:0]       matrix_reg;
    logic [SCREEN_BITS-1:0] width_reg, height_reg;

    q_status_t  q_status;
    logic       push, pop;
    clip_item_t push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW0:   matrix_reg[0] <= cfg_data;
                REG_ROW1:   matrix_reg[1] <= cfg_data;
                REG_ROW2:   matrix_reg[2] <= cfg_data;
                REG_ROW3:   matrix_reg[3] <= cfg_data;
                REG_WIDTH:  width_reg     <= cfg_data[SCREEN_BITS-1:0];
                REG_HEIGHT: height_reg    <= cfg_data[SCREEN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    wsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (matrix_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    wsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .q_status      (q_status),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

endmodule

>>> tb/tb_world_to_screen_projection.sv
module tb_world_to_screen_projection;
    import wsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class projection_scoreboard;
        logic [63:0]            mrow [4];
        logic [SCREEN_BITS-1:0] width;
        logic [SCREEN_BITS-1:0] height;
        out_item_t              pending_q [$];
        int                     errors;

        function new();
            for (int r = 0; r < 4; r++)
                mrow[r] = '0;
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] d);
            case (idx)
                REG_ROW0:   mrow[0] = d;
                REG_ROW1:   mrow[1] = d;
                REG_ROW2:   mrow[2] = d;
                REG_ROW3:   mrow[3] = d;
                REG_WIDTH:  width  = d[SCREEN_BITS-1:0];
                REG_HEIGHT: height = d[SCREEN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // row times (x, y, z, 1.0) in Q.28
        function longint row_dot(int r, longint px, longint py, longint pz);
            longint e [4];
            for (int c = 0; c < 4; c++)
                e[c] = longint'($signed(mrow[r][16*c +: 16]));
            return e[0] * px + e[1] * py + e[2] * pz + e[3] * 64'sd65536;
        endfunction

        function logic [OUT_BITS-1:0] scale(longint a, logic [SCREEN_BITS-1:0] s, longint w);
            logic [127:0] num;
            num = 128'(a) * 128'({s, 3'b000});
            return OUT_BITS'(num / 128'(w));
        endfunction

        function void note_point(in_item_t p);
            longint    cx, cy, cz, cw;
            out_item_t res;
            cx = row_dot(0, p.pos_x, p.pos_y, p.pos_z);
            cy = row_dot(1, p.pos_x, p.pos_y, p.pos_z);
            cz = row_dot(2, p.pos_x, p.pos_y, p.pos_z);
            cw = row_dot(3, p.pos_x, p.pos_y, p.pos_z);
            res = '0;
            if (cw > 64'sd26843 && cx >= -cw && cx <= cw && cy >= -cw && cy <= cw
                && cz >= -cw && cz <= cw)
            begin
                res.visible  = 1'b1;
                res.screen_x = scale(cx + cw, width, cw);
                res.screen_y = scale(cw - cy, height, cw);
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.visible !== exp.visible)
            begin
                $error("visible: expected %0d actual %0d", exp.visible, got.visible);
                errors++;
            end
            if (got.screen_x !== exp.screen_x)
            begin
                $error("screen_x: expected %0d actual %0d", exp.screen_x, got.screen_x);
                errors++;
            end
            if (got.screen_y !== exp.screen_y)
            begin
                $error("screen_y: expected %0d actual %0d", exp.screen_y, got.screen_y);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;

    projection_scoreboard sb = new();
    int gap_pct;
    int stall_pct;

    world_to_screen_projection u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_point(in_item);
        if (out_valid && !out_stall)
            sb.check_result(out_item);
    end

    function logic [63:0] pack_row(int e0, int e1, int e2, int e3);
        return {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
    endfunction

    // writes all six registers back to back
    task load_cfg(logic [63:0] v [6]);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= v[i];
            @(posedge clk);
            sb.write_reg(cfg_reg_t'(i), v[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task send_point(int px, int py, int pz);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid      <= 1'b1;
        in_item.pos_x <= px;
        in_item.pos_y <= py;
        in_item.pos_z <= pz;
        do @(posedge clk); while (in_stall);
    endtask

    task drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function int small_coord();
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    function int rand_entry();
        if ($urandom_range(9) == 0)
            return int'($urandom());
        return $urandom_range(0, 8192) - 4096;
    endfunction

    logic [63:0] regs [6];

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_stall <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrix: w is zero, nothing visible
        send_point(0, 0, 0);
        send_point(32'h7fffffff, 32'h80000000, 32'h12345678);
        drain();

        // identity with w = 1.0
        regs[0] = pack_row(4096, 0, 0, 0);
        regs[1] = pack_row(0, 4096, 0, 0);
        regs[2] = pack_row(0, 0, 4096, 0);
        regs[3] = pack_row(0, 0, 0, 4096);
        regs[4] = 64'd640;
        regs[5] = 64'd480;
        load_cfg(regs);
        send_point(0, 0, 0);
        send_point(65536, 65536, 65536);     // on the clip boundary
        send_point(-65536, -65536, -65536);
        send_point(65537, 0, 0);             // just outside
        send_point(0, -65537, 0);
        send_point(0, 0, 65537);
        send_point(32'h7fffffff, 0, 0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32768, -12345, 100);
        drain();

        // w from x alone: exactly epsilon is behind, one above is in front
        regs[0] = pack_row(0, 0, 0, 0);
        regs[1] = pack_row(0, 0, 0, 0);
        regs[2] = pack_row(0, 0, 0, 0);
        regs[3] = pack_row(1, 0, 0, 0);
        regs[4] = 64'hffff_ffff_ffff_f000;   // width wraps to zero
        regs[5] = 64'd4095;
        load_cfg(regs);
        send_point(26843, 0, 0);
        send_point(26844, 0, 0);
        send_point(-26844, 0, 0);
        send_point(32'h7fffffff, 7, -7);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (int r = 0; r < 3; r++)
                regs[r] = pack_row(rand_entry(), rand_entry(), rand_entry(), rand_entry());
            regs[3] = pack_row(rand_entry() / 8, rand_entry() / 8, rand_entry() / 8,
                               $urandom_range(2048, 16384));
            if (phase == 3)
                for (int r = 0; r < 4; r++)
                    regs[r] = {$urandom(), $urandom()};
            case (phase)
                0: begin regs[4] = 64'd4095; regs[5] = 64'd4095; end
                1: begin regs[4] = 64'd1;    regs[5] = 64'd1;    end
                5: begin regs[4] = {$urandom(), $urandom()}; regs[5] = 64'h1000; end
                default:
                begin
                    regs[4] = $urandom_range(1, 4095);
                    regs[5] = $urandom_range(1, 4095);
                end
            endcase
            load_cfg(regs);
            for (int n = 0; n < 235; n++)
            begin
                if ($urandom_range(99) < 75)
                    send_point(small_coord(), small_coord(), small_coord());
                else
                    send_point(int'($urandom()), int'($urandom()), int'($urandom()));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_front.sv
rtl/core/wsp_queue.sv
rtl/core/wsp_back.sv
rtl/core/world_to_screen_projection.sv
tb/tb_world_to_screen_projection.sv
